// ----- hw/rtl/utmm_pkg.sv -----
`timescale 1ns / 1ps
package utmm_pkg;

  // Result element width and index widths
  localparam int RES_W = 36;
  localparam int DIM_W = 4;
  localparam int IDX_W = 3;

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Request actions
  typedef enum logic [1:0] {
    ACT_TRI  = 2'd0,
    ACT_WORK = 2'd1,
    ACT_RUN  = 2'd2
  } act_t;

  // Operations carried down the cell chain
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_PIVOT = 3'd1,
    OP_ADD   = 3'd2,
    OP_SCALE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [DIM_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic             we;
    logic [DIM_W-1:0] row;
    logic [RES_W-1:0] data;
  } load_t;

  typedef struct packed {
    logic             valid;
    logic [DIM_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [RES_W-1:0] data;
  } emit_t;

endpackage

// ----- hw/rtl/utmm_ram.sv -----
`timescale 1ns / 1ps
module utmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/utmm_cell.sv -----
`timescale 1ns / 1ps
module utmm_cell #(
  parameter int ELEM_WIDTH = 16,
  parameter int DEPTH      = 8,
  parameter int IDX        = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  utmm_pkg::cmd_t                      cmd_in,
  input  logic signed [ELEM_WIDTH-1:0]        u_in,
  input  logic [utmm_pkg::DIM_W-1:0]          cols,
  input  utmm_pkg::load_t                     load,
  output utmm_pkg::cmd_t                      cmd_out,
  output logic signed [ELEM_WIDTH-1:0]        u_out,
  output utmm_pkg::emit_t                     emit
);

  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int RW = utmm_pkg::RES_W;

  utmm_pkg::cmd_t                   cmd_q;
  logic signed [ELEM_WIDTH-1:0]     u_q;
  logic signed [RW-1:0]             rdata;
  logic signed [RW-1:0]             pivot;
  logic signed [RW-1:0]             mul_b;
  logic signed [ELEM_WIDTH+RW-1:0]  full;
  logic [RW-1:0]                    prod_q;
  logic [RW-1:0]                    rd_q;
  utmm_pkg::op_t                    op2;
  logic [utmm_pkg::DIM_W-1:0]       row2;
  logic                             wb;
  logic                             we;
  logic [AW-1:0]                    waddr;
  logic [RW-1:0]                    wdata;

  // Column store of this cell
  utmm_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_col (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (AW'(cmd_in.row)),
    .rdata (rdata)
  );

  // Hand the request on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q.op <= utmm_pkg::OP_NOP;
    end else begin
      cmd_q.op <= cmd_in.op;
    end
    cmd_q.row <= cmd_in.row;
    u_q       <= u_in;
  end

  // Drop the request past the last column in use
  always_comb begin
    cmd_out = cmd_q;
    if (IDX + 1 >= int'(cols)) begin
      cmd_out.op = utmm_pkg::OP_NOP;
    end
  end

  assign u_out   = u_q;

  // Multiply by the pivot row element, or by the own element when scaling
  assign mul_b = (cmd_q.op == utmm_pkg::OP_SCALE) ? rdata : pivot;
  assign full  = u_q * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      op2 <= utmm_pkg::OP_NOP;
    end else begin
      op2 <= cmd_q.op;
    end
    if (cmd_q.op == utmm_pkg::OP_PIVOT) begin
      pivot <= rdata;
    end
    prod_q <= full[RW-1:0];
    rd_q   <= rdata;
    row2   <= cmd_q.row;
  end

  // Write back, loads take the port while idle
  assign wb    = (op2 == utmm_pkg::OP_ADD) || (op2 == utmm_pkg::OP_SCALE);
  assign we    = load.we || wb;
  assign waddr = load.we ? AW'(load.row) : AW'(row2);
  assign wdata = load.we ? load.data :
                 (op2 == utmm_pkg::OP_SCALE) ? prod_q : rd_q + prod_q;

  // Present the read element when this column is in use
  assign emit.valid = (cmd_q.op == utmm_pkg::OP_READ) && (IDX < int'(cols));
  assign emit.row   = cmd_q.row;
  assign emit.col   = utmm_pkg::IDX_W'(IDX);
  assign emit.data  = rdata;

endmodule

// ----- hw/rtl/upper_triangular_matrix_multiply_top.sv -----
`timescale 1ns / 1ps
// A load request is written while idle. A compute request sweeps the cell
// chain row by row, then reads the result out, one element per cycle.
// Throughput: one request at a time; busy is high from compute to the last result.
// Reset (rst, synchronous) clears control and sets both dimensions to 8; the
// stores hold nothing defined until written. The receiver cannot stall results.
module upper_triangular_matrix_multiply_top #(
  parameter int MAX_ROWS   = 8,
  parameter int MAX_COLS   = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic [2:0]                        row,
  input  logic [2:0]                        col,
  input  logic signed [ELEM_WIDTH-1:0]      value,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [3:0]                        cfg_data,
  output logic                              strobe,
  output logic [2:0]                        out_row,
  output logic [2:0]                        out_col,
  output logic signed [35:0]                result,
  output logic                              last
);

  localparam int TDEPTH = MAX_ROWS * MAX_ROWS;
  localparam int TAW    = TDEPTH > 1 ? $clog2(TDEPTH) : 1;
  localparam int DW     = utmm_pkg::DIM_W;
  localparam int RW     = utmm_pkg::RES_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PIVOT  = 8'b0000_0010,
    S_ADD    = 8'b0000_0100,
    S_SCALE  = 8'b0000_1000,
    S_GAP    = 8'b0001_0000,
    S_SETTLE = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_DRAIN  = 8'b1000_0000
  } state_t;

  state_t                        state;
  logic [DW-1:0]                 rows_in_use;
  logic [DW-1:0]                 cols_in_use;
  logic [DW-1:0]                 n;
  logic [DW-1:0]                 m;
  logic [DW-1:0]                 i;
  logic [DW-1:0]                 r;
  logic [DW-1:0]                 cc;
  logic                          accept;
  logic                          tri_we;
  logic                          work_ok;
  logic [DW-1:0]                 ta_r;
  logic [TAW-1:0]                tri_raddr;
  logic signed [ELEM_WIDTH-1:0]  tri_rdata;
  utmm_pkg::cmd_t                cmd_seq;
  utmm_pkg::cmd_t                cmd0;
  utmm_pkg::cmd_t                cmd_ch [MAX_COLS+1];
  logic signed [ELEM_WIDTH-1:0]  u_ch [MAX_COLS+1];
  utmm_pkg::emit_t               emits [MAX_COLS];
  logic [MAX_COLS-1:0]           emit_vld;
  utmm_pkg::emit_t               emit_all;
  logic                          emit_last;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= DW'(8);
      cols_in_use <= DW'(8);
    end else if (cfg_we) begin
      if (cfg_index == utmm_pkg::CFG_COLS) begin
        cols_in_use <= cfg_data;
      end else begin
        rows_in_use <= cfg_data;
      end
    end
  end

  // Clamp dimensions into range
  assign n = (rows_in_use == '0) ? DW'(1) :
             (int'(rows_in_use) > MAX_ROWS) ? DW'(MAX_ROWS) : rows_in_use;
  assign m = (cols_in_use == '0) ? DW'(1) :
             (int'(cols_in_use) > MAX_COLS) ? DW'(MAX_COLS) : cols_in_use;

  // Decode load requests
  always_comb begin
    tri_we  = 1'b0;
    work_ok = 1'b0;
    if (accept) begin
      unique case (utmm_pkg::act_t'(action))
        utmm_pkg::ACT_TRI:  tri_we  = (int'(row) < MAX_ROWS) && (int'(col) < MAX_ROWS);
        utmm_pkg::ACT_WORK: work_ok = (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);
        default: ;
      endcase
    end
  end

  // Triangular store
  utmm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(TDEPTH)) u_tri (
    .clk   (clk),
    .we    (tri_we),
    .waddr (TAW'(int'(row) * MAX_ROWS + int'(col))),
    .wdata (value),
    .raddr (tri_raddr),
    .rdata (tri_rdata)
  );

  // Sweep and readout requests
  always_comb begin
    cmd_seq.op  = utmm_pkg::OP_NOP;
    cmd_seq.row = i;
    ta_r        = i;
    unique case (state)
      S_PIVOT: cmd_seq.op = utmm_pkg::OP_PIVOT;
      S_ADD: begin
        cmd_seq.op  = utmm_pkg::OP_ADD;
        cmd_seq.row = r;
        ta_r        = r;
      end
      S_SCALE: cmd_seq.op = utmm_pkg::OP_SCALE;
      S_EMIT: begin
        cmd_seq.row = r;
        if (cc == '0) begin
          cmd_seq.op = utmm_pkg::OP_READ;
        end
      end
      default: ;
    endcase
  end

  assign tri_raddr = TAW'(int'(ta_r) * MAX_ROWS + int'(i));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (utmm_pkg::act_t'(action) == utmm_pkg::ACT_RUN)) begin
            i     <= '0;
            state <= S_PIVOT;
          end
        end
        S_PIVOT: begin
          r     <= '0;
          state <= (i == '0) ? S_SCALE : S_ADD;
        end
        S_ADD: begin
          if (r == i - DW'(1)) begin
            state <= S_SCALE;
          end
          r <= r + DW'(1);
        end
        S_SCALE: state <= S_GAP;
        S_GAP: begin
          if (i == n - DW'(1)) begin
            state <= S_SETTLE;
          end else begin
            i     <= i + DW'(1);
            state <= S_PIVOT;
          end
        end
        S_SETTLE: begin
          r     <= '0;
          cc    <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (cc == m - DW'(1)) begin
            cc <= '0;
            r  <= r + DW'(1);
            if (r == n - DW'(1)) begin
              state <= S_DRAIN;
            end
          end else begin
            cc <= cc + DW'(1);
          end
        end
        S_DRAIN: begin
          if (emit_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Head of the chain, aligned with the triangular read
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd0.op <= utmm_pkg::OP_NOP;
    end else begin
      cmd0.op <= cmd_seq.op;
    end
    cmd0.row <= cmd_seq.row;
  end

  assign cmd_ch[0] = cmd0;
  assign u_ch[0]   = tri_rdata;

  // Row of column cells
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    utmm_pkg::load_t ld;
    assign ld.we   = work_ok && (int'(col) == c);
    assign ld.row  = DW'(row);
    assign ld.data = {{(RW-ELEM_WIDTH){value[ELEM_WIDTH-1]}}, value};

    utmm_cell #(.ELEM_WIDTH(ELEM_WIDTH), .DEPTH(MAX_ROWS), .IDX(c)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd_in  (cmd_ch[c]),
      .u_in    (u_ch[c]),
      .cols    (m),
      .load    (ld),
      .cmd_out (cmd_ch[c+1]),
      .u_out   (u_ch[c+1]),
      .emit    (emits[c])
    );
    assign emit_vld[c] = emits[c].valid;
  end

  // Merge the single element presented this cycle
  always_comb begin
    emit_all = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      emit_all = emit_all | (emits[c].valid ? emits[c] : '0);
    end
  end

  assign emit_last = emit_all.valid && (emit_all.row == n - DW'(1)) &&
                     (emit_all.col == utmm_pkg::IDX_W'(m - DW'(1)));

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= emit_all.valid;
      last   <= emit_last;
    end
    out_row <= emit_all.row[2:0];
    out_col <= emit_all.col;
    result  <= emit_all.data;
  end

`ifndef SYNTHESIS
  a_one_emitter: assert property (@(posedge clk) disable iff (rst)
    $onehot0(emit_vld))
    else $error("several cells present an element at once");

  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe)
    else $error("last without strobe");

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == S_EMIT || state == S_DRAIN))
    else $error("result outside readout");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !emit_all.valid && (cmd_ch[MAX_COLS].op != utmm_pkg::OP_READ))
    else $error("readout activity while idle");
`endif

endmodule

// ----- tb/sv/utmm_result_checker.sv -----
`timescale 1ns / 1ps
module utmm_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action,
  input  logic [2:0]  row,
  input  logic [2:0]  col,
  input  logic [15:0] value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        strobe,
  input  logic [2:0]  out_row,
  input  logic [2:0]  out_col,
  input  logic [35:0] result,
  input  logic        last,
  output int          pending,
  output int          errors,
  output int          products_seen
);

  typedef struct {
    logic [2:0]  r;
    logic [2:0]  c;
    logic [35:0] v;
    logic        fin;
  } elem_t;

  elem_t       product_q[$];
  logic [15:0] tri_mat[64];
  logic [35:0] work_mat[64];
  logic [3:0]  rows_reg;
  logic [3:0]  cols_reg;

  function automatic int clamp_dim(input logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  // Run the row sweep and queue every element of U*B in row-major order
  task automatic predict_product();
    int n, m;
    logic [35:0] u, d;
    elem_t e;
    n = clamp_dim(rows_reg);
    m = clamp_dim(cols_reg);
    for (int i = 0; i < n; i++) begin
      for (int r = 0; r < i; r++) begin
        u = {{20{tri_mat[r*8+i][15]}}, tri_mat[r*8+i]};
        for (int c = 0; c < m; c++)
          work_mat[r*8+c] = work_mat[r*8+c] + u * work_mat[i*8+c];
      end
      d = {{20{tri_mat[i*8+i][15]}}, tri_mat[i*8+i]};
      for (int c = 0; c < m; c++)
        work_mat[i*8+c] = d * work_mat[i*8+c];
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < m; c++) begin
        e.r = 3'(r);
        e.c = 3'(c);
        e.v = work_mat[r*8+c];
        e.fin = (r == n-1) && (c == m-1);
        product_q.push_back(e);
      end
  endtask

  task automatic report(input string what);
    errors++;
    if (errors <= 10) $display("ERROR: %s", what);
  endtask

  always @(posedge clk) begin
    elem_t e;
    if (rst) begin
      rows_reg <= 4'd8;
      cols_reg <= 4'd8;
      product_q.delete();
    end else begin
      // compare a product element against the oldest expectation
      if (strobe) begin
        products_seen++;
        if (product_q.size() == 0) begin
          report($sformatf("unexpected element (%0d,%0d) %0d", out_row, out_col,
                           $signed(result)));
        end else begin
          e = product_q.pop_front();
          if (out_row !== e.r || out_col !== e.c || result !== e.v || last !== e.fin)
            report($sformatf("exp (%0d,%0d) %0d last %0d, got (%0d,%0d) %0d last %0d",
                             e.r, e.c, $signed(e.v), e.fin, out_row, out_col,
                             $signed(result), last));
        end
      end
      // apply an accepted request
      if (start && !busy) begin
        case (action)
          utmm_pkg::ACT_TRI:  tri_mat[row*8+col] = value;
          utmm_pkg::ACT_WORK: work_mat[row*8+col] = {{20{value[15]}}, value};
          utmm_pkg::ACT_RUN:  predict_product();
          default: ;
        endcase
      end
      if (cfg_we) begin
        if (cfg_index == utmm_pkg::CFG_ROWS) rows_reg <= cfg_data;
        else if (cfg_index == utmm_pkg::CFG_COLS) cols_reg <= cfg_data;
      end
    end
    pending = product_q.size();
  end

  initial begin
    errors = 0;
    products_seen = 0;
    pending = 0;
  end
endmodule

// ----- tb/sv/tb_upper_triangular_matrix_multiply_top.sv -----
`timescale 1ns / 1ps
module tb_upper_triangular_matrix_multiply_top;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         LIMIT      = 600000;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [1:0]  action = utmm_pkg::ACT_TRI;
  logic [2:0]  row = 0;
  logic [2:0]  col = 0;
  logic [15:0] value = 0;
  logic        cfg_we = 0;
  logic        cfg_index = utmm_pkg::CFG_ROWS;
  logic [3:0]  cfg_data = 0;
  logic        busy, strobe, last;
  logic [2:0]  out_row, out_col;
  logic [35:0] result;
  int          pending, errors, products_seen;
  int          cycles = 0;
  int          requests = 0;
  int          runs = 0;
  int          n_eff = 8;
  int          m_eff = 8;
  int          gap_mode = 0;
  bit          tri_set[64];
  bit          work_set[64];

  always #10 clk = ~clk;

  upper_triangular_matrix_multiply_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .row(row),
    .col(col), .value(value), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .strobe(strobe), .out_row(out_row), .out_col(out_col),
    .result(result), .last(last)
  );

  utmm_result_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .row(row),
    .col(col), .value(value), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .strobe(strobe), .out_row(out_row), .out_col(out_col),
    .result(result), .last(last), .pending(pending), .errors(errors),
    .products_seen(products_seen)
  );

  // abandon a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Hold a request until accepted, then sometimes idle for a random gap
  task automatic issue(input logic [1:0] a, input logic [2:0] r, input logic [2:0] c,
                       input logic [15:0] v);
    int g;
    start = 1;
    action = a;
    row = r;
    col = c;
    value = v;
    do @(posedge clk); while (busy);
    requests++;
    if (a == utmm_pkg::ACT_TRI) tri_set[r*8+c] = 1;
    if (a == utmm_pkg::ACT_WORK) work_set[r*8+c] = 1;
    if (a == utmm_pkg::ACT_RUN) runs++;
    @(negedge clk);
    g = 0;
    if (gap_mode != 0 && $urandom_range(0, 2) == 0)
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    if (g > 0) begin
      start = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Wait until every product element is back, then let the block settle
  task automatic drain();
    start = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [3:0] d);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 0;
    if (idx == utmm_pkg::CFG_ROWS) n_eff = (d == 0) ? 1 : (d > 8) ? 8 : d;
    else m_eff = (d == 0) ? 1 : (d > 8) ? 8 : d;
  endtask

  // Load any entry the sweep will read that was never written, then compute
  task automatic run_product();
    for (int i = 0; i < n_eff; i++) begin
      for (int r = 0; r <= i; r++)
        if (!tri_set[r*8+i]) issue(utmm_pkg::ACT_TRI, 3'(r), 3'(i), pick_value());
      for (int c = 0; c < m_eff; c++)
        if (!work_set[i*8+c]) issue(utmm_pkg::ACT_WORK, 3'(i), 3'(c), pick_value());
    end
    issue(utmm_pkg::ACT_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
  endtask

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    int loads;
    repeat (6) @(negedge clk);
    rst = 0;

    // directed: single element at the extremes, clamped sizes, unused action
    set_reg(utmm_pkg::CFG_ROWS, 4'd1);
    set_reg(utmm_pkg::CFG_COLS, 4'd1);
    issue(utmm_pkg::ACT_TRI, 3'd0, 3'd0, 16'h8000);
    issue(utmm_pkg::ACT_WORK, 3'd0, 3'd0, 16'h8000);
    issue(ACT_UNUSED, 3'd7, 3'd7, 16'hffff);
    run_product();
    issue(utmm_pkg::ACT_TRI, 3'd7, 3'd0, 16'h7fff);
    set_reg(utmm_pkg::CFG_ROWS, 4'd0);
    set_reg(utmm_pkg::CFG_COLS, 4'd15);
    issue(utmm_pkg::ACT_WORK, 3'd0, 3'd7, 16'h7fff);
    run_product();
    set_reg(utmm_pkg::CFG_ROWS, 4'd8);
    set_reg(utmm_pkg::CFG_COLS, 4'd8);
    run_product();
    run_product();

    // random phases of loads followed by a compute
    while (requests < 450) begin
      gap_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) set_reg(utmm_pkg::CFG_ROWS, pick_dim());
      if ($urandom_range(0, 2) == 0) set_reg(utmm_pkg::CFG_COLS, pick_dim());
      loads = $urandom_range(0, 10);
      repeat (loads)
        issue(($urandom_range(0, 19) == 0) ? ACT_UNUSED : 2'($urandom_range(0, 1)),
              3'($urandom), 3'($urandom), pick_value());
      run_product();
    end

    drain();
    repeat (100) @(negedge clk);
    $display("Covered %0d requests, %0d computes, %0d product elements checked.",
             requests, runs, products_seen);
    $display("Sizes 0 to 15 written to both registers; gaps and back-to-back loads mixed.");
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/utmm_pkg.sv
hw/rtl/utmm_ram.sv
hw/rtl/utmm_cell.sv
hw/rtl/upper_triangular_matrix_multiply_top.sv
tb/sv/utmm_result_checker.sv
tb/sv/tb_upper_triangular_matrix_multiply_top.sv
